>>> design/apb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// apb_pkg
// Shared types and constants of the audio playout ring buffer.
// ---------------------------------------------------------------------------
package apb_pkg;

   localparam int SAMPLE_W = 16;
   localparam int LEVEL_W  = 13;
   localparam int COUNT_W  = 32;

   localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = LEVEL_W'(1024);

   typedef enum logic [1:0] {
      REQ_PUSH   = 2'd0,
      REQ_PULL   = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_STATUS = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_FRAME
   } ctl_state_type;

   typedef struct packed {
      logic [1:0]                 req_type;
      logic signed [SAMPLE_W-1:0] push_sample;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_sample;
      logic                       sample_valid;
      logic                       last;
      logic [LEVEL_W-1:0]         fill_level;
      logic [LEVEL_W-1:0]         peak_level;
      logic [COUNT_W-1:0]         pushed_total;
      logic [COUNT_W-1:0]         drained_total;
      logic [COUNT_W-1:0]         dropped_total;
      logic [COUNT_W-1:0]         underrun_total;
      logic                       playing;
      logic                       idle_empty;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic take_req;
      logic emit_word;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic frame_start;
      logic last_slot;
      logic slot_free;
   } dp_status_type;

endpackage
`default_nettype wire

>>> design/apb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// apb_ctrl
// Sequencer: takes requests while idle and paces the words of a frame.
// ---------------------------------------------------------------------------
module apb_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire apb_pkg::dp_status_type status,
   output apb_pkg::ctl_cmd_type        cmd
);
   import apb_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.take_req  = 1'b0;
      cmd.emit_word = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = status.slot_free;
            cmd.take_req = req_valid && status.slot_free;
            if (cmd.take_req && status.frame_start) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // let the memory read settle on the read pointer
            state_in = ST_FRAME;
         end
         ST_FRAME: begin
            cmd.emit_word = status.slot_free;
            if (cmd.emit_word && status.last_slot) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.take_req && cmd.emit_word))
      else $error("request taken while a frame word is emitted");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("ready raised outside idle");

   a_prep_then_frame: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_req && status.frame_start) |=> ##1 state_ff == ST_FRAME)
      else $error("frame did not start after prep");

endmodule
`default_nettype wire

>>> design/apb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// apb_datapath
// Sample ring memory, pointers, fill and statistics, and the output word.
// ---------------------------------------------------------------------------
module apb_datapath #(
   parameter int RING_DEPTH    = 4096,
   parameter int FRAME_SAMPLES = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire apb_pkg::req_word_type          req_data,
   input  wire logic                           csr_wr_en,
   input  wire logic [apb_pkg::LEVEL_W-1:0]    csr_wr_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output apb_pkg::rsp_word_type               rsp_data,
   input  wire apb_pkg::ctl_cmd_type           cmd,
   output apb_pkg::dp_status_type              status
);
   import apb_pkg::*;

   localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FILL_W = $clog2(RING_DEPTH + 1);
   localparam int IDX_W  = $clog2(FRAME_SAMPLES + 1);
   localparam int CMP_W  = (FILL_W > LEVEL_W) ? FILL_W : LEVEL_W;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
   logic [SAMPLE_W-1:0] rd_q_ff;

   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FILL_W-1:0]  peak_ff, peak_in;
   logic [COUNT_W-1:0] pushed_ff, pushed_in;
   logic [COUNT_W-1:0] drained_ff, drained_in;
   logic [COUNT_W-1:0] dropped_ff, dropped_in;
   logic [COUNT_W-1:0] underrun_ff, underrun_in;
   logic               active_ff, active_in;
   logic [LEVEL_W-1:0] thresh_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   nsamp_ff, nsamp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_ff, rsp_in;

   logic [CMP_W-1:0]   fill_x;
   logic [IDX_W-1:0]   nsamp_calc;
   logic               plays;
   logic               is_push;
   logic               is_pull;
   logic               load_word;
   logic               in_frame;

   assign fill_x     = CMP_W'(fill_ff);
   assign nsamp_calc = (fill_x < CMP_W'(FRAME_SAMPLES)) ? IDX_W'(fill_ff)
                                                        : IDX_W'(FRAME_SAMPLES);
   assign plays      = active_ff || (fill_x >= CMP_W'(thresh_ff));
   assign is_push    = req_data.req_type == REQ_PUSH;
   assign is_pull    = req_data.req_type == REQ_PULL;
   assign in_frame   = idx_ff < nsamp_ff;

   assign status.frame_start = is_pull && plays && (fill_ff != '0);
   assign status.last_slot   = idx_ff == IDX_W'(FRAME_SAMPLES - 1);
   assign status.slot_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      fill_in     = fill_ff;
      peak_in     = peak_ff;
      pushed_in   = pushed_ff;
      drained_in  = drained_ff;
      dropped_in  = dropped_ff;
      underrun_in = underrun_ff;
      active_in   = active_ff;
      idx_in      = idx_ff;
      nsamp_in    = nsamp_ff;

      if (cmd.take_req) begin
         case (req_data.req_type)
            REQ_PUSH: begin
               wr_ptr_in = ptr_inc(wr_ptr_ff);
               pushed_in = pushed_ff + 1'b1;
               if (fill_ff == FILL_W'(RING_DEPTH)) begin
                  // overwrite the oldest sample
                  rd_ptr_in  = ptr_inc(rd_ptr_ff);
                  dropped_in = dropped_ff + 1'b1;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
               if (fill_in > peak_ff) begin
                  peak_in = fill_in;
               end
            end
            REQ_PULL: begin
               if (plays) begin
                  if (fill_ff == '0) begin
                     active_in   = 1'b0;
                     underrun_in = underrun_ff + 1'b1;
                  end else begin
                     active_in  = 1'b1;
                     fill_in    = fill_ff - FILL_W'(nsamp_calc);
                     drained_in = drained_ff + COUNT_W'(nsamp_calc);
                     idx_in     = '0;
                     nsamp_in   = nsamp_calc;
                  end
               end
            end
            REQ_CLEAR: begin
               wr_ptr_in   = '0;
               rd_ptr_in   = '0;
               fill_in     = '0;
               peak_in     = '0;
               pushed_in   = '0;
               drained_in  = '0;
               dropped_in  = '0;
               underrun_in = '0;
               active_in   = 1'b0;
            end
            REQ_STATUS: begin
            end
            default: begin
            end
         endcase
      end

      if (cmd.emit_word) begin
         idx_in = idx_ff + 1'b1;
         if (in_frame) begin
            rd_ptr_in = ptr_inc(rd_ptr_ff);
         end
      end
   end

   assign load_word = (cmd.take_req && !status.frame_start) || cmd.emit_word;

   always_comb begin
      rsp_in.out_sample     = (cmd.emit_word && in_frame) ? rd_q_ff : '0;
      rsp_in.sample_valid   = cmd.emit_word;
      rsp_in.last           = !cmd.emit_word || status.last_slot;
      rsp_in.fill_level     = LEVEL_W'(fill_in);
      rsp_in.peak_level     = LEVEL_W'(peak_in);
      rsp_in.pushed_total   = pushed_in;
      rsp_in.drained_total  = drained_in;
      rsp_in.dropped_total  = dropped_in;
      rsp_in.underrun_total = underrun_in;
      rsp_in.playing        = active_in;
      rsp_in.idle_empty     = (fill_in == '0) && !active_in;
      rsp_valid_in          = load_word ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         peak_ff      <= '0;
         pushed_ff    <= '0;
         drained_ff   <= '0;
         dropped_ff   <= '0;
         underrun_ff  <= '0;
         active_ff    <= 1'b0;
         thresh_ff    <= THRESHOLD_RESET;
         idx_ff       <= '0;
         nsamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         peak_ff      <= peak_in;
         pushed_ff    <= pushed_in;
         drained_ff   <= drained_in;
         dropped_ff   <= dropped_in;
         underrun_ff  <= underrun_in;
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         nsamp_ff     <= nsamp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_word) begin
         rsp_ff <= rsp_in;
      end
   end

   // sample ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.take_req && is_push) begin
         ring_mem[wr_ptr_ff] <= req_data.push_sample;
      end
   end

   // track the word under the next read pointer
   always_ff @(posedge clock) begin
      rd_q_ff <= ring_mem[rd_ptr_in];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(RING_DEPTH))
      else $error("fill level above ring depth");

   a_peak_covers_fill: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= fill_ff)
      else $error("peak below fill level");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff <= PTR_W'(RING_DEPTH - 1)) && (rd_ptr_ff <= PTR_W'(RING_DEPTH - 1)))
      else $error("ring pointer out of range");

endmodule
`default_nettype wire

>>> design/audio_playout_ring_buffer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// audio_playout_ring_buffer_top
// Audio playout jitter buffer: sample ring with prebuffer start and frames.
// ---------------------------------------------------------------------------
// Requests arrive on req_valid/req_ready with a req_data word: push a
// sample, pull one frame, clear, or read status. Results leave on
// rsp_valid/rsp_ready; every result word carries fill, peak, the wrapping
// counters and the play flags as they stand after the request.
// Push, clear, status and a pull that plays nothing give one word with
// last set, registered at accept; the next request is taken in the same
// cycle the word is taken, so with rsp_ready high they run at one per cycle.
// A pull that plays gives FRAME_SAMPLES words, stored samples first, then
// zero padding, last on the final one. It holds the request side through
// a prep state that sets up the single read port of the sample memory,
// then the frame state, one word per cycle through that port unless stalled.
// A stall on rsp_ready holds the output word and pauses the frame; the
// request side waits while the output word is occupied and not taken.
// The prebuffer threshold is written on csr_wr_en; the user must write it
// only while idle, which the block does not enforce. Reset empties the ring,
// zeroes counters and peak, stops playback and sets the threshold to 1024;
// memory contents are not cleared and are only read after being written.
// ---------------------------------------------------------------------------
module audio_playout_ring_buffer_top #(
   parameter int RING_DEPTH    = 4096,
   parameter int FRAME_SAMPLES = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire apb_pkg::req_word_type       req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output apb_pkg::rsp_word_type            rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [apb_pkg::LEVEL_W-1:0] csr_wr_data
);
   import apb_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   apb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   apb_datapath #(
      .RING_DEPTH    (RING_DEPTH),
      .FRAME_SAMPLES (FRAME_SAMPLES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
`default_nettype wire

>>> bench/tb_audio_playout_ring_buffer_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_audio_playout_ring_buffer_top
// Self-checking bench for the audio playout ring buffer.
// ---------------------------------------------------------------------------
// A short table of requests checks the block after reset, at sample
// extremes, at threshold zero and with a small threshold. Random phases of
// push bursts and pulls follow under several thresholds, then thresholds
// at, above and far above the ring depth are tried on a lightly filled ring.
// A behavioral copy of the ring predicts every result word, and words are
// compared field by field in order. Both handshakes idle at random, and
// once the receiver holds off long enough to back up the request side.
// ---------------------------------------------------------------------------
module tb_audio_playout_ring_buffer_top;
   import apb_pkg::*;

   localparam int DEPTH      = 4096;
   localparam int FRAME      = 32;
   localparam int CYCLE_CAP  = 1000000;
   localparam int SQUEEZE_CY = 400;

   typedef struct packed {
      bit                 is_cfg;
      logic [LEVEL_W-1:0] cfg_value;
      req_word_type       word;
      bit                 known;
      rsp_word_type       want;
   } drill_row_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   req_word_type       req_data    = '0;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   rsp_word_type       rsp_data;
   logic               csr_wr_en   = 1'b0;
   logic [LEVEL_W-1:0] csr_wr_data = '0;

   // copy of the ring and its bookkeeping
   logic [SAMPLE_W-1:0] ring_copy [0:DEPTH-1];
   logic [11:0]         wr_ptr_q      = '0;
   logic [11:0]         rd_ptr_q      = '0;
   logic [LEVEL_W-1:0]  fill_q        = '0;
   logic [LEVEL_W-1:0]  peak_q        = '0;
   logic [COUNT_W-1:0]  pushed_q      = '0;
   logic [COUNT_W-1:0]  drained_q     = '0;
   logic [COUNT_W-1:0]  dropped_q     = '0;
   logic [COUNT_W-1:0]  underrun_q    = '0;
   logic                active_q      = 1'b0;
   logic [LEVEL_W-1:0]  threshold_q   = THRESHOLD_RESET;

   rsp_word_type  playout_expect [$];
   drill_row_type drill [$];
   rsp_word_type  want_word;

   int  fail_count     = 0;
   int  words_checked  = 0;
   int  frames_checked = 0;
   int  cycle_count    = 0;
   bit  calm           = 1'b0;
   bit  squeeze_pending = 1'b0;

   audio_playout_ring_buffer_top #(
      .RING_DEPTH   (DEPTH),
      .FRAME_SAMPLES(FRAME)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("%0t: timeout, %0d words still expected", $time, playout_expect.size());
         $display("** audio_playout_ring_buffer_top: FAILED **");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic rsp_word_type model_word(logic [SAMPLE_W-1:0] smp, logic vld, logic lst);
      rsp_word_type w;
      w.out_sample     = smp;
      w.sample_valid   = vld;
      w.last           = lst;
      w.fill_level     = fill_q;
      w.peak_level     = peak_q;
      w.pushed_total   = pushed_q;
      w.drained_total  = drained_q;
      w.dropped_total  = dropped_q;
      w.underrun_total = underrun_q;
      w.playing        = active_q;
      w.idle_empty     = (fill_q == '0) && !active_q;
      return w;
   endfunction

   function automatic rsp_word_type summary_word(int fill, int peak, int pushed, int drained,
                                                 int dropped, int underrun, bit play);
      rsp_word_type w;
      w.out_sample     = '0;
      w.sample_valid   = 1'b0;
      w.last           = 1'b1;
      w.fill_level     = LEVEL_W'(fill);
      w.peak_level     = LEVEL_W'(peak);
      w.pushed_total   = COUNT_W'(pushed);
      w.drained_total  = COUNT_W'(drained);
      w.dropped_total  = COUNT_W'(dropped);
      w.underrun_total = COUNT_W'(underrun);
      w.playing        = play;
      w.idle_empty     = (fill == 0) && !play;
      return w;
   endfunction

   // advance the ring copy by one request and queue the words it causes
   task automatic playout_step(input req_word_type w);
      logic [SAMPLE_W-1:0] frame_buf [0:FRAME-1];
      int                  n;
      int                  i;
      n = 0;
      case (w.req_type)
         REQ_PUSH: begin
            if (fill_q == LEVEL_W'(DEPTH)) begin
               // full: overwrite the oldest sample
               rd_ptr_q   = rd_ptr_q + 1'b1;
               fill_q     = fill_q - 1'b1;
               dropped_q  = dropped_q + 1'b1;
            end
            ring_copy[wr_ptr_q] = w.push_sample;
            wr_ptr_q = wr_ptr_q + 1'b1;
            fill_q   = fill_q + 1'b1;
            if (fill_q > peak_q)
               peak_q = fill_q;
            pushed_q = pushed_q + 1'b1;
         end
         REQ_CLEAR: begin
            wr_ptr_q   = '0;
            rd_ptr_q   = '0;
            fill_q     = '0;
            peak_q     = '0;
            pushed_q   = '0;
            drained_q  = '0;
            dropped_q  = '0;
            underrun_q = '0;
            active_q   = 1'b0;
         end
         REQ_PULL: begin
            if (!active_q && fill_q >= threshold_q)
               active_q = 1'b1;
            if (active_q) begin
               n = (fill_q < FRAME) ? int'(fill_q) : FRAME;
               if (n == 0) begin
                  active_q   = 1'b0;
                  underrun_q = underrun_q + 1'b1;
               end else begin
                  for (i = 0; i < FRAME; i++) begin
                     if (i < n) begin
                        frame_buf[i] = ring_copy[rd_ptr_q];
                        rd_ptr_q = rd_ptr_q + 1'b1;
                     end else begin
                        frame_buf[i] = '0;
                     end
                  end
                  fill_q    = fill_q - LEVEL_W'(n);
                  drained_q = drained_q + COUNT_W'(n);
                  for (i = 0; i < FRAME; i++)
                     playout_expect.push_back(model_word(frame_buf[i], 1'b1, i == FRAME - 1));
                  return;
               end
            end
         end
         default: begin
         end
      endcase
      playout_expect.push_back(model_word('0, 1'b0, 1'b1));
   endtask

   // offer one word and wait for it to be taken; valid is left high
   task automatic send_req(input req_code_type code, input logic [SAMPLE_W-1:0] smp,
                           input bit known, input rsp_word_type want);
      int           gap;
      req_word_type w;
      gap = pick_gap();
      w.req_type    = code;
      w.push_sample = smp;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      playout_step(w);
      if (known) begin
         void'(playout_expect.pop_back());
         playout_expect.push_back(want);
      end
   endtask

   task automatic offer(input req_code_type code, input logic [SAMPLE_W-1:0] smp);
      send_req(code, smp, 1'b0, '0);
   endtask

   task automatic drain_out();
      req_valid <= 1'b0;
      while (playout_expect.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [LEVEL_W-1:0] value);
      drain_out();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      threshold_q = value;
   endtask

   task automatic random_phase(input int n_items);
      int sent;
      int r;
      int k;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            // well-formed: a burst of samples, then one or more frame periods
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            repeat (k) begin
               case ($urandom_range(0, 15))
                  0:       offer(REQ_PUSH, 16'h7FFF);
                  1:       offer(REQ_PUSH, 16'h8000);
                  default: offer(REQ_PUSH, 16'($urandom_range(0, 65535)));
               endcase
            end
            sent = sent + k;
            k = $urandom_range(1, 3);
            repeat (k) offer(REQ_PULL, 16'($urandom_range(0, 65535)));
            sent = sent + k;
         end else if (r < 88) begin
            offer(REQ_STATUS, 16'($urandom_range(0, 65535)));
            sent++;
         end else if (r < 94) begin
            offer(REQ_CLEAR, 16'($urandom_range(0, 65535)));
            sent++;
         end else begin
            offer(REQ_PULL, 16'($urandom_range(0, 65535)));
            sent++;
         end
      end
   endtask

   function automatic drill_row_type step_row(req_code_type code, logic [SAMPLE_W-1:0] smp);
      drill_row_type row;
      row = '0;
      row.word.req_type    = code;
      row.word.push_sample = smp;
      return row;
   endfunction

   function automatic drill_row_type known_row(req_code_type code, logic [SAMPLE_W-1:0] smp,
                                               rsp_word_type want);
      drill_row_type row;
      row       = step_row(code, smp);
      row.known = 1'b1;
      row.want  = want;
      return row;
   endfunction

   function automatic drill_row_type cfg_row(logic [LEVEL_W-1:0] value);
      drill_row_type row;
      row           = '0;
      row.is_cfg    = 1'b1;
      row.cfg_value = value;
      return row;
   endfunction

   function automatic void check_field(string fname, longint unsigned e, longint unsigned a);
      if (e != a) begin
         fail_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, e, a);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (playout_expect.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected word, expected none, actual %p", $time, rsp_data);
         end else begin
            want_word = playout_expect.pop_front();
            check_field("out_sample",     want_word.out_sample,     rsp_data.out_sample);
            check_field("sample_valid",   want_word.sample_valid,   rsp_data.sample_valid);
            check_field("last",           want_word.last,           rsp_data.last);
            check_field("fill_level",     want_word.fill_level,     rsp_data.fill_level);
            check_field("peak_level",     want_word.peak_level,     rsp_data.peak_level);
            check_field("pushed_total",   want_word.pushed_total,   rsp_data.pushed_total);
            check_field("drained_total",  want_word.drained_total,  rsp_data.drained_total);
            check_field("dropped_total",  want_word.dropped_total,  rsp_data.dropped_total);
            check_field("underrun_total", want_word.underrun_total, rsp_data.underrun_total);
            check_field("playing",        want_word.playing,        rsp_data.playing);
            check_field("idle_empty",     want_word.idle_empty,     rsp_data.idle_empty);
            words_checked++;
            if (rsp_data.sample_valid && rsp_data.last)
               frames_checked++;
         end
      end
   end

   // receiver: runs of ready with random stalls, plus one long hold-off
   initial begin
      int run;
      int stall;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (squeeze_pending) begin
            rsp_ready <= 1'b0;
            repeat (SQUEEZE_CY) @(posedge clock);
            squeeze_pending = 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            run = calm ? 50 : $urandom_range(1, 20);
            repeat (run) @(posedge clock);
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   initial begin
      int                 i;
      logic [LEVEL_W-1:0] phase_thr [0:4];

      drill.push_back(known_row(REQ_STATUS, 16'h0000, summary_word(0, 0, 0, 0, 0, 0, 0)));
      drill.push_back(known_row(REQ_PULL,   16'h0000, summary_word(0, 0, 0, 0, 0, 0, 0)));
      drill.push_back(known_row(REQ_PUSH,   16'h7FFF, summary_word(1, 1, 1, 0, 0, 0, 0)));
      drill.push_back(known_row(REQ_PUSH,   16'h8000, summary_word(2, 2, 2, 0, 0, 0, 0)));
      drill.push_back(step_row(REQ_PUSH,    16'hFFFF));
      drill.push_back(step_row(REQ_PUSH,    16'h0000));
      drill.push_back(step_row(REQ_PUSH,    16'h5555));
      drill.push_back(step_row(REQ_PUSH,    16'hAAAA));
      drill.push_back(known_row(REQ_CLEAR,  16'hFFFF, summary_word(0, 0, 0, 0, 0, 0, 0)));
      // threshold zero: a pull on an empty ring starts and underruns at once
      drill.push_back(cfg_row(13'd0));
      drill.push_back(known_row(REQ_PULL,   16'h0000, summary_word(0, 0, 0, 0, 0, 1, 0)));
      drill.push_back(step_row(REQ_PUSH,    16'h1234));
      drill.push_back(step_row(REQ_PUSH,    16'h4321));
      drill.push_back(step_row(REQ_PULL,    16'h0000));
      drill.push_back(step_row(REQ_PULL,    16'h0000));
      drill.push_back(step_row(REQ_STATUS,  16'h0000));
      drill.push_back(cfg_row(13'd3));
      drill.push_back(step_row(REQ_PUSH,    16'h0F0F));
      drill.push_back(step_row(REQ_PUSH,    16'hF0F0));
      drill.push_back(step_row(REQ_PULL,    16'h0000));
      drill.push_back(step_row(REQ_PUSH,    16'h00FF));
      drill.push_back(step_row(REQ_PULL,    16'h0000));
      drill.push_back(known_row(REQ_CLEAR,  16'h0000, summary_word(0, 0, 0, 0, 0, 0, 0)));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < drill.size(); i++) begin
         if (drill[i].is_cfg)
            write_threshold(drill[i].cfg_value);
         else
            send_req(req_code_type'(drill[i].word.req_type), drill[i].word.push_sample,
                     drill[i].known, drill[i].want);
      end

      phase_thr[0] = 13'd1;
      phase_thr[1] = 13'd32;
      phase_thr[2] = LEVEL_W'($urandom_range(2, 40));
      phase_thr[3] = 13'd0;
      phase_thr[4] = 13'd33;
      for (i = 0; i < 5; i++) begin
         write_threshold(phase_thr[i]);
         calm = (i == 3);
         // back up the request side while words keep coming
         if (i == 1)
            squeeze_pending = 1'b1;
         random_phase(10);
      end

      // thresholds above, far above and at the ring depth keep an idle ring silent
      write_threshold(LEVEL_W'(DEPTH + 1));
      offer(REQ_CLEAR, 16'h0000);
      repeat (4) offer(REQ_PUSH, 16'($urandom_range(0, 65535)));
      offer(REQ_PULL, 16'h0000);
      write_threshold(13'h1FFF);
      offer(REQ_PULL, 16'h0000);
      write_threshold(LEVEL_W'(DEPTH));
      offer(REQ_PULL, 16'h0000);
      offer(REQ_STATUS, 16'h0000);
      write_threshold(THRESHOLD_RESET);
      repeat (8) offer(REQ_PUSH, 16'($urandom_range(0, 65535)));
      offer(REQ_PULL, 16'h0000);
      offer(REQ_CLEAR, 16'h0000);
      offer(REQ_STATUS, 16'h0000);

      drain_out();
      repeat (40) @(posedge clock);

      $display("Checked %0d result words, %0d of them closing a played frame.",
               words_checked, frames_checked);
      $display("Thresholds ran from 0 to 8191, with one long receiver hold-off on the way.");
      if (fail_count == 0)
         $display("** audio_playout_ring_buffer_top: PASSED **");
      else
         $display("** audio_playout_ring_buffer_top: FAILED **");
      $finish;
   end

endmodule
